// ===== design/sha1s_pkg.sv =====
// Shared types, constants and state encodings for the SHA-1 stream hasher.
package sha1s_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
  } out_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] PHASE1    = 7'd20;
  localparam logic [6:0] PHASE2    = 7'd40;
  localparam logic [6:0] PHASE3    = 7'd60;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP_GO,
    S_COMP_WAIT,
    S_PAD,
    S_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_FOLD
  } core_state_e;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_EMIT
  } ret_e;

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       start;
    logic       chain_init;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

endpackage

// ===== design/sha1s_core.sv =====
// SHA-1 compression unit: block window, schedule, one round per cycle and chain value.
module sha1s_core import sha1s_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_ctl_t ctl_i,
  output core_sts_t sts_o,
  output out_t      chain_o
);

  core_state_e state_q, state_d;
  logic [6:0]   round_q, round_d;
  logic [511:0] win_q, win_d;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  a_d, b_d, c_d, d_d, e_d;
  out_t         chain_q, chain_d;

  logic [31:0] wt, w_mix, w_next, f, k, tmp;

  // window holds w[t..t+15], w[t] in the top word
  assign wt     = win_q[511 -: 32];
  assign w_mix  = win_q[511 -: 32] ^ win_q[447 -: 32] ^ win_q[255 -: 32] ^ win_q[95 -: 32];
  assign w_next = {w_mix[30:0], w_mix[31]};

  always_comb begin
    priority if (round_q < PHASE1) begin
      f = (b_q & c_q) ^ (~b_q & d_q);
      k = K0;
    end else if (round_q < PHASE2) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (round_q < PHASE3) begin
      f = (b_q & c_q) ^ (b_q & d_q) ^ (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
  end

  assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    win_d   = win_q;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    chain_d = chain_q;
    sts_o   = '0;

    unique case (state_q)
      C_IDLE: begin
        if (ctl_i.start) begin
          a_d = chain_q.digest_word0;
          b_d = chain_q.digest_word1;
          c_d = chain_q.digest_word2;
          d_d = chain_q.digest_word3;
          e_d = chain_q.digest_word4;
          round_d = '0;
          state_d = C_ROUND;
        end else if (ctl_i.push) begin
          win_d = {win_q[503:0], ctl_i.push_byte};
        end
        if (ctl_i.chain_init) begin
          chain_d = '{IV0, IV1, IV2, IV3, IV4};
        end
      end
      C_ROUND: begin
        sts_o.busy = 1'b1;
        a_d = tmp;
        b_d = a_q;
        c_d = {b_q[1:0], b_q[31:2]};
        d_d = c_q;
        e_d = d_q;
        win_d   = {win_q[479:0], w_next};
        round_d = round_q + 7'd1;
        if (round_q == ROUND_LAST) begin
          state_d = C_FOLD;
        end
      end
      C_FOLD: begin
        sts_o.busy = 1'b1;
        sts_o.done = 1'b1;
        chain_d.digest_word0 = chain_q.digest_word0 + a_q;
        chain_d.digest_word1 = chain_q.digest_word1 + b_q;
        chain_d.digest_word2 = chain_q.digest_word2 + c_q;
        chain_d.digest_word3 = chain_q.digest_word3 + d_q;
        chain_d.digest_word4 = chain_q.digest_word4 + e_q;
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      round_q <= '0;
      chain_q <= '{IV0, IV1, IV2, IV3, IV4};
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  assign chain_o = chain_q;

  ast_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> state_q == C_IDLE)
    else $error("compression started while busy");

  ast_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> state_q == C_IDLE)
    else $error("byte pushed during compression");

  ast_fold_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == C_FOLD |-> $past(state_q) == C_ROUND && $past(round_q) == ROUND_LAST)
    else $error("fold without a full set of rounds");

endmodule

// ===== design/sha1_stream_hasher.sv =====
// SHA-1 over a byte stream: byte intake, padding sequencer and digest output register.
// Flow: a byte beat is taken as soon as it is presented while idle; the 64th byte of a block
// adds a compression (start, 80 rounds on one shared round unit, chain fold). An end beat
// adds a padding step per remaining block byte plus one or two compressions, then a load of
// the digest. Plain byte beats sustain 1 per cycle until a full block stalls the input.
// Reset: asynchronous active low; chain value, counters and handshake state return to init.
module sha1_stream_hasher import sha1s_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  top_state_e state_q, state_d;
  ret_e       ret_q, ret_d;
  logic [5:0]  pos_q, pos_d;
  logic [63:0] len_q, len_d;
  logic        pad_first_q, pad_first_d;
  logic        two_blk_q, two_blk_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_data_q, out_data_d;

  core_ctl_t core_ctl;
  core_sts_t core_sts;
  out_t      chain;

  logic two_blk_nxt;

  sha1s_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (core_ctl),
    .sts_o   (core_sts),
    .chain_o (chain)
  );

  // marker landing in the length field forces an extra all-padding block
  assign two_blk_nxt = two_blk_q | (pad_first_q && pos_q >= LEN_POS);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    pos_d       = pos_q;
    len_d       = len_q;
    pad_first_d = pad_first_q;
    two_blk_d   = two_blk_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    core_ctl    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pad_first_d = 1'b1;
          two_blk_d   = 1'b0;
          if (in_data_i.has_byte) begin
            core_ctl.push      = 1'b1;
            core_ctl.push_byte = in_data_i.data_byte;
            pos_d = pos_q + 6'd1;
            len_d = len_q + 64'd8;
          end
          if (in_data_i.has_byte && pos_q == LAST_POS) begin
            state_d = S_COMP_GO;
            ret_d   = in_data_i.end_of_message ? RET_PAD : RET_IDLE;
          end else if (in_data_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_COMP_GO: begin
        core_ctl.start = 1'b1;
        state_d = S_COMP_WAIT;
      end
      S_COMP_WAIT: begin
        if (core_sts.done) begin
          unique case (ret_q)
            RET_IDLE: state_d = S_IDLE;
            RET_PAD:  state_d = S_PAD;
            RET_EMIT: state_d = S_EMIT;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_PAD: begin
        core_ctl.push = 1'b1;
        pos_d = pos_q + 6'd1;
        priority if (pad_first_q) begin
          core_ctl.push_byte = PAD_BYTE;
        end else if (!two_blk_q && pos_q >= LEN_POS) begin
          // big-endian length, top byte first
          core_ctl.push_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];
        end else begin
          core_ctl.push_byte = ZERO_BYTE;
        end
        pad_first_d = 1'b0;
        two_blk_d   = two_blk_nxt;
        if (pos_q == LAST_POS) begin
          state_d   = S_COMP_GO;
          ret_d     = two_blk_nxt ? RET_PAD : RET_EMIT;
          two_blk_d = 1'b0;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = chain;
          core_ctl.chain_init = 1'b1;
          pos_d   = '0;
          len_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= RET_IDLE;
      pos_q       <= '0;
      len_q       <= '0;
      pad_first_q <= 1'b1;
      two_blk_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      pad_first_q <= pad_first_d;
      two_blk_q   <= two_blk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  ast_accept_core_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !core_sts.busy)
    else $error("beat taken while compression runs");

  ast_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_sts.done |-> state_q == S_COMP_WAIT)
    else $error("compression finished outside wait state");

  ast_emit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> pos_q == '0 && !two_blk_q)
    else $error("digest emitted with a part-filled block");

endmodule

// ===== bench/sha1_stream_hasher_tb.sv =====
// Self-checking testbench for the SHA-1 stream hasher: directed rows, then random messages.
`timescale 1ns / 100ps

module sha1_stream_hasher_tb;
  import sha1s_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int          HOLD_CYCLES = 3000;
  localparam int          PHASE_ITEMS = 135;

  localparam out_t EMPTY_DG = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                               32'h95601890, 32'hafd80709};
  localparam out_t ABC_DG   = {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                               32'h7850c26c, 32'h9cd0d89d};
  localparam out_t NUL_DG   = {32'h5ba93c9d, 32'hb0cff93f, 32'h52b521d7,
                               32'h420e43f6, 32'heda2784f};

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    in_t  beat;
    bit   known;
    out_t digest;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // expected digests, oldest first
  out_t        digest_q[$];
  dir_row_t    dir_rows[$];
  idle_mode_e  mode;
  bit          hold_req;
  int          n_err;
  int          n_items;
  int          n_digests;
  int unsigned cycles;

  // hasher model state
  logic [31:0] chain_h[5];
  logic [31:0] msg_words[16];
  logic [5:0]  fill_cnt;
  logic [63:0] len_bits;

  sha1_stream_hasher u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int src_idle_pct();
    case (mode)
      IDLE_SRC:  return 49;
      IDLE_BOTH: return 6;
      default:   return 0;
    endcase
  endfunction

  function automatic int snk_stall_pct();
    case (mode)
      IDLE_SNK:  return 49;
      IDLE_BOTH: return 6;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic in_t mk_beat(input logic [7:0] d, input logic hb, input logic eom);
    return '{data_byte: d, has_byte: hb, end_of_message: eom};
  endfunction

  task automatic chain_reset();
    chain_h[0] = IV0;
    chain_h[1] = IV1;
    chain_h[2] = IV2;
    chain_h[3] = IV3;
    chain_h[4] = IV4;
    fill_cnt   = '0;
    len_bits   = '0;
  endtask

  task automatic put_byte(input logic [5:0] pos, input logic [7:0] b);
    msg_words[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
  endtask

  task automatic sha1_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    int t;
    w = msg_words;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rol32(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15], 1);
        w[t & 15] = wt;
      end
      if (t < 20) begin
        f = (b & c) ^ (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) ^ (b & d) ^ (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      tmp = rol32(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  // advance the model by one accepted beat; got is set when a digest falls out
  task automatic absorb_beat(input in_t bt, output bit got, output out_t dg);
    int p;
    got = 1'b0;
    dg  = '0;
    if (bt.has_byte) begin
      put_byte(fill_cnt, bt.data_byte);
      len_bits += 64'd8;
      fill_cnt += 6'd1;
      if (fill_cnt == '0) sha1_block();
    end
    if (bt.end_of_message) begin
      p = int'(fill_cnt);
      put_byte(p[5:0], PAD_BYTE);
      p++;
      if (p > LEN_POS) begin
        while (p <= LAST_POS) begin
          put_byte(p[5:0], ZERO_BYTE);
          p++;
        end
        sha1_block();
        p = 0;
      end
      while (p < LEN_POS) begin
        put_byte(p[5:0], ZERO_BYTE);
        p++;
      end
      msg_words[14] = len_bits[63:32];
      msg_words[15] = len_bits[31:0];
      sha1_block();
      dg  = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
      got = 1'b1;
      chain_reset();
    end
  endtask

  task automatic send_beat(input in_t bt, input bit use_known, input out_t known_dg);
    bit   got;
    out_t dg;
    while ($urandom_range(0, 99) < src_idle_pct()) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= bt;
    do @(posedge clk_i); while (in_stall_o);
    absorb_beat(bt, got, dg);
    if (bt.has_byte || bt.end_of_message) n_items++;
    if (got) digest_q.push_back(use_known ? known_dg : dg);
  endtask

  task automatic send_message(input int len);
    bit on_byte;
    int i;
    on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0), 1'b0, '0);
      send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b1, on_byte && (i == len - 1)),
                1'b0, '0);
    end
    if (!on_byte) send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1), 1'b0, '0);
  endtask

  // mostly short messages, with a share sitting on the padding boundaries
  function automatic int pick_len();
    int r;
    int edges[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 20);
    if (r < 85) return edges[$urandom_range(0, 9)];
    if (r < 97) return $urandom_range(21, 130);
    return $urandom_range(131, 300);
  endfunction

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_row(input in_t bt, input bit known, input out_t dg);
    dir_rows.push_back('{beat: bt, known: known, digest: dg});
  endtask

  // receiver: random stall per cycle, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(0, 99) < snk_stall_pct());
    end
  end

  always @(posedge clk_i) begin
    out_t exp_dg;
    int   i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $display("%t unexpected digest %h", $time, out_data_o);
        n_err++;
      end else begin
        exp_dg = digest_q.pop_front();
        n_digests++;
        for (i = 0; i < 5; i++) begin
          if (out_data_o[159 - 32 * i -: 32] !== exp_dg[159 - 32 * i -: 32]) begin
            $display("%t digest_word%0d exp %h got %h", $time, i,
                     exp_dg[159 - 32 * i -: 32], out_data_o[159 - 32 * i -: 32]);
            n_err++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sha1_stream_hasher_tb: errors");
      $finish;
    end
  end

  initial begin
    int ph;
    int start;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    hold_req   = 1'b0;
    mode       = IDLE_NONE;
    n_err      = 0;
    n_items    = 0;
    n_digests  = 0;
    cycles     = 0;
    chain_reset();
    msg_words  = '{default: '0};

    // empty messages, ignored beats, "abc" both ways, single-byte extremes
    add_row(mk_beat(8'h00, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'hff, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h00, 1'b0, 1'b1), 1'b1, EMPTY_DG);
    add_row(mk_beat(8'h5a, 1'b0, 1'b1), 1'b1, EMPTY_DG);
    add_row(mk_beat(8'h61, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h62, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h63, 1'b1, 1'b1), 1'b1, ABC_DG);
    add_row(mk_beat(8'h61, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h62, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h63, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'hff, 1'b0, 1'b1), 1'b1, ABC_DG);
    add_row(mk_beat(8'h00, 1'b1, 1'b1), 1'b1, NUL_DG);
    add_row(mk_beat(8'hff, 1'b1, 1'b1), 1'b0, '0);
    add_row(mk_beat(8'h80, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h33, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h7f, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h01, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'hfe, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk_beat(8'h00, 1'b0, 1'b1), 1'b0, '0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r])
      send_beat(dir_rows[r].beat, dir_rows[r].known, dir_rows[r].digest);
    wait_drained();

    for (ph = 0; ph < 8; ph++) begin
      mode  = idle_mode_e'(ph % 4);
      start = n_items;
      while (n_items - start < PHASE_ITEMS) send_message(pick_len());
      wait_drained();
      if (ph == 3) begin
        // output held off while messages keep coming, so the input backs up
        mode     = IDLE_NONE;
        hold_req = 1'b1;
        repeat (6) send_message($urandom_range(0, 70));
        wait_drained();
      end
    end

    repeat (300) @(posedge clk_i);

    if (n_err == 0 && digest_q.size() == 0) begin
      $display("sha1_stream_hasher_tb: clean");
    end else begin
      $display("sha1_stream_hasher_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sha1s_pkg.sv
design/sha1s_core.sv
design/sha1_stream_hasher.sv
bench/sha1_stream_hasher_tb.sv
